// ===== rtl/core/efb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_pkg: shared types and constants for the Ethernet frame builder
// Frame limits, CRC constants, the command word between front and back end,
// and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
package efb_pkg;

  localparam int MAX_PAYLOAD = 1500;
  localparam int MIN_PAYLOAD = 46;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int PAD_W       = $clog2(MIN_PAYLOAD + 1);
  localparam int HDR_LEN     = 14;
  localparam int HDR_IDX_W   = 4;
  localparam int SEQ_W       = (PAD_W > HDR_IDX_W) ? PAD_W : HDR_IDX_W;
  localparam int FCS_LEN     = 4;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // One command word: a payload byte (with header ahead of it) or an abort
  typedef struct packed {
    logic             hdr;
    logic             abort;
    logic             last;
    logic [PAD_W-1:0] pad;
    logic [7:0]       data;
    logic [47:0]      dest_mac;
    logic [15:0]      ether_type;
  } cmd_t;

  // Reflected CRC-32 over one byte, LSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/ethernet_frame_builder.sv =====
`timescale 1ns / 1ps
// An accepted word passes the command queue and then the output register to the output.
// The back-end sequencer sets the pace of one frame byte per cycle while m_tready
// does not stall it; payload words flow at one per cycle, header, pad and FCS bytes
// hold input off once the 4-entry command queue fills.
// Reset (rst, synchronous, active high) closes any open frame, empties the
// queue, clears the output and sets the source MAC to zero.
// ----------------------------------------------------------------------------
// ethernet_frame_builder: Ethernet II framing with CRC-32 FCS
// Front end classifies payload words, a queue decouples it from the back end
// that emits header, payload, pad and FCS bytes.
// ----------------------------------------------------------------------------
module ethernet_frame_builder
  import efb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [47:0] cfg_data,      // local station MAC
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,       // payload_byte[7:0], dest_mac[55:8], ether_type[71:56]
  input  logic        s_tlast,       // payload_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,       // frame_byte[7:0]
  output logic        m_tlast,       // frame_end
  output logic        m_tuser        // frame_error
);

  logic [47:0] station_mac;
  logic        push;
  cmd_t        push_cmd;
  logic        q_full;
  logic        pop;
  logic        head_valid;
  cmd_t        head_cmd;

  // station MAC register
  always_ff @(posedge clk) begin
    if (rst) begin
      station_mac <= '0;
    end else if (cfg_we) begin
      station_mac <= cfg_data;
    end
  end

  efb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .payload_byte (s_tdata[7:0]),
    .payload_last (s_tlast),
    .dest_mac     (s_tdata[55:8]),
    .ether_type   (s_tdata[71:56]),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  efb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  efb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .station_mac (station_mac),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .out_end     (m_tlast),
    .out_error   (m_tuser)
  );

endmodule

// ===== rtl/core/efb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_queue: command queue between front and back end
// Small register FIFO; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module efb_queue
  import efb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W + 1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_level_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue level did not follow push");

endmodule

// ===== rtl/core/efb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_front: input classifier
// Tracks frame, payload count and drop state per input word and issues one
// command per word that yields output.
// ----------------------------------------------------------------------------
module efb_front
  import efb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  payload_byte,
  input  logic        payload_last,
  input  logic [47:0] dest_mac,
  input  logic [15:0] ether_type,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        q_full
);

  logic             in_frame;
  logic             dropping;
  logic [CNT_W-1:0] payload_count;

  logic             in_frame_next;
  logic             dropping_next;
  logic [CNT_W-1:0] payload_count_next;
  logic             accept;
  logic             first;
  logic             drop_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] cnt_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign first    = !in_frame;
  assign drop_eff = first ? 1'b0 : dropping;
  assign cnt_eff  = first ? '0 : payload_count;
  assign cnt_inc  = cnt_eff + 1'b1;

  // classify the word
  always_comb begin
    push                = 1'b0;
    push_cmd.hdr        = first;
    push_cmd.abort      = 1'b0;
    push_cmd.last       = payload_last;
    push_cmd.pad        = '0;
    push_cmd.data       = payload_byte;
    push_cmd.dest_mac   = dest_mac;
    push_cmd.ether_type = ether_type;
    in_frame_next       = in_frame;
    dropping_next       = dropping;
    payload_count_next  = payload_count;
    if (accept) begin
      in_frame_next = 1'b1;
      if (drop_eff) begin
        // discarding the tail of an aborted frame
        dropping_next = 1'b1;
      end else if (cnt_eff >= CNT_W'(MAX_PAYLOAD)) begin
        push               = 1'b1;
        push_cmd.abort     = 1'b1;
        dropping_next      = 1'b1;
        payload_count_next = cnt_eff;
      end else begin
        push               = 1'b1;
        dropping_next      = 1'b0;
        payload_count_next = cnt_inc;
        if (cnt_inc < CNT_W'(MIN_PAYLOAD)) begin
          push_cmd.pad = PAD_W'(CNT_W'(MIN_PAYLOAD) - cnt_inc);
        end
      end
      if (payload_last) begin
        in_frame_next      = 1'b0;
        dropping_next      = 1'b0;
        payload_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      dropping      <= 1'b0;
      payload_count <= '0;
    end else begin
      in_frame      <= in_frame_next;
      dropping      <= dropping_next;
      payload_count <= payload_count_next;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    payload_count <= CNT_W'(MAX_PAYLOAD))
    else $error("payload count above maximum");
  a_drop_in_frame: assert property (@(posedge clk) disable iff (rst) dropping |-> in_frame)
    else $error("dropping outside a frame");
  a_abort_no_hdr: assert property (@(posedge clk) disable iff (rst)
    (push && push_cmd.abort) |-> !push_cmd.hdr)
    else $error("abort issued on the opening word");

endmodule

// ===== rtl/core/efb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_back: frame sequencer
// Walks each command through header, payload, pad and FCS bytes, one byte
// per unstalled cycle into an output register, with the running CRC-32.
// ----------------------------------------------------------------------------
module efb_back
  import efb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [47:0] station_mac,
  input  logic        head_valid,
  input  cmd_t        head_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_end,
  output logic        out_error
);

  typedef enum logic [4:0] {
    S_NEXT = 5'b00001,
    S_HDR  = 5'b00010,
    S_DATA = 5'b00100,
    S_PAD  = 5'b01000,
    S_FCS  = 5'b10000
  } state_t;

  state_t           state;
  logic [SEQ_W-1:0] cnt;
  logic [31:0]      crc;

  state_t             state_next;
  logic [SEQ_W-1:0]   cnt_next;
  logic [7:0]         byte_val;
  logic               end_val;
  logic               err_val;
  logic               feed;
  logic               restart;
  logic               pop_c;
  logic               need_cmd;
  logic               advance;
  logic               go;
  logic [31:0]        fcs;
  logic [111:0]       hdr_vec;
  logic [HDR_IDX_W-1:0] hdr_sel;
  logic [HDR_IDX_W-1:0] hdr_idx;

  assign fcs     = crc ^ CRC_ONES;
  assign hdr_vec = {head_cmd.dest_mac, station_mac, head_cmd.ether_type};
  assign hdr_idx = (state == S_HDR) ? cnt[HDR_IDX_W-1:0] : '0;
  assign hdr_sel = HDR_IDX_W'(HDR_LEN - 1) - hdr_idx;

  assign need_cmd = (state == S_NEXT) || (state == S_HDR) || (state == S_DATA);
  assign advance  = !out_valid || out_ready;
  assign go       = advance && (!need_cmd || head_valid);
  assign pop      = go && pop_c;

  // byte selection and sequencing
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    byte_val   = 8'd0;
    end_val    = 1'b0;
    err_val    = 1'b0;
    feed       = 1'b0;
    restart    = 1'b0;
    pop_c      = 1'b0;
    case (state)
      S_NEXT, S_DATA: begin
        if (head_cmd.abort) begin
          end_val    = 1'b1;
          err_val    = 1'b1;
          pop_c      = 1'b1;
          state_next = S_NEXT;
        end else if (state == S_NEXT && head_cmd.hdr) begin
          byte_val   = hdr_vec[{hdr_sel, 3'b000} +: 8];
          feed       = 1'b1;
          restart    = 1'b1;
          state_next = S_HDR;
          cnt_next   = SEQ_W'(1);
        end else begin
          byte_val = head_cmd.data;
          feed     = 1'b1;
          pop_c    = 1'b1;
          if (!head_cmd.last) begin
            state_next = S_NEXT;
          end else if (head_cmd.pad != '0) begin
            state_next = S_PAD;
            cnt_next   = SEQ_W'(head_cmd.pad);
          end else begin
            state_next = S_FCS;
            cnt_next   = '0;
          end
        end
      end
      S_HDR: begin
        byte_val = hdr_vec[{hdr_sel, 3'b000} +: 8];
        feed     = 1'b1;
        if (cnt == SEQ_W'(HDR_LEN - 1)) begin
          state_next = S_DATA;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_PAD: begin
        feed = 1'b1;
        if (cnt == SEQ_W'(1)) begin
          state_next = S_FCS;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_FCS: begin
        byte_val = fcs[{cnt[1:0], 3'b000} +: 8];
        if (cnt == SEQ_W'(FCS_LEN - 1)) begin
          end_val    = 1'b1;
          state_next = S_NEXT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = S_NEXT;
        cnt_next   = '0;
      end
    endcase
  end

  // sequencer state and CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_NEXT;
      cnt   <= '0;
      crc   <= CRC_ONES;
    end else if (go) begin
      state <= state_next;
      cnt   <= cnt_next;
      if (feed) begin
        crc <= crc32_byte(restart ? CRC_ONES : crc, byte_val);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_byte  <= byte_val;
      out_end   <= end_val;
      out_error <= err_val;
    end
  end

  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_error) |-> out_end)
    else $error("error word not marked as frame end");
  a_hdr_has_cmd: assert property (@(posedge clk) disable iff (rst)
    (state == S_HDR || state == S_DATA) |-> head_valid)
    else $error("command left the queue mid header");
  a_fcs_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FCS) |-> (cnt < SEQ_W'(FCS_LEN)))
    else $error("FCS byte index out of range");
  a_pad_to_fcs: assert property (@(posedge clk) disable iff (rst)
    (go && state == S_PAD && cnt == SEQ_W'(1)) |=> (state == S_FCS))
    else $error("pad did not hand over to FCS");

endmodule
